// ===== rtl/core/swts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted word table search package
// Shared constants, codes, structs and the character fold function.
// ----------------------------------------------------------------------------
package swts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int MAX_CHARS   = 8;
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = MAX_CHARS * CHAR_W;
    localparam int LEN_W       = 4;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = IDX_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_MODE = 2'd3;

    // transaction actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // answer selection
    localparam logic [MODE_W-1:0] MODE_COUNT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCATION = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [LEN_W-1:0] WORD_LENGTH_RST = LEN_W'(MAX_CHARS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_READ
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]  word_length;
        logic [IDX_W-1:0]  entry_count;
        logic              case_fold;
        logic [MODE_W-1:0] result_mode;
    } t_cfg;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] location;
        logic [IDX_W-1:0] answer;
    } t_result;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sorted_word_table_search_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted word table search unit
// Loads 64-bit words into a sorted table and bisects it for a key.
// ----------------------------------------------------------------------------
// Load: no result, busy stays low; the next transaction may start in the next cycle.
// Search: each probe sets the table read address in S_PROBE and compares the
//   registered read word in S_READ, one probe per step of the bisection; the
//   result strobe is registered with the result, after a hit or an empty range.
// busy stays high during a search; results cannot be stalled.
// Synchronous active-low reset clears control and configuration; table
//   contents are undefined until loaded.
module sorted_word_table_search_unit
    import swts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_action,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [WORD_W-1:0]     i_key_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_location,
    output logic [IDX_W-1:0]      o_answer
);

    t_cfg              r_cfg;
    logic              accept;
    logic              load_we;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    t_result           res;

    assign accept    = start && !busy;
    assign load_we   = accept && (i_action == ACT_LOAD) && (i_entry_index != '0)
                       && (i_entry_index <= IDX_W'(TABLE_DEPTH));
    assign load_addr = ADDR_W'(i_entry_index - IDX_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.word_length <= WORD_LENGTH_RST;
            r_cfg.entry_count <= '0;
            r_cfg.case_fold   <= 1'b0;
            r_cfg.result_mode <= MODE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WORD_LENGTH: r_cfg.word_length <= i_cfg_data[LEN_W-1:0];
                CFG_ENTRY_COUNT: r_cfg.entry_count <= i_cfg_data[IDX_W-1:0];
                CFG_CASE_FOLD:   r_cfg.case_fold   <= i_cfg_data[0];
                CFG_RESULT_MODE: r_cfg.result_mode <= i_cfg_data[MODE_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    swts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (load_addr),
        .i_wdata (i_key_word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    swts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept && (i_action == ACT_SEARCH)),
        .i_key   (i_key_word),
        .i_cfg   (r_cfg),
        .i_rdata (rdata),
        .o_raddr (raddr),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_res   (res)
    );

    assign o_found    = res.found;
    assign o_location = res.location;
    assign o_answer   = res.answer;

endmodule

// ===== rtl/core/swts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/swts_cmp.sv =====
// ----------------------------------------------------------------------------
// Word compare unit
// Orders a key against a table word on the first word_length (1..8) chars.
// ----------------------------------------------------------------------------
module swts_cmp
    import swts_pkg::*;
(
    input  logic [WORD_W-1:0] i_key,
    input  logic [WORD_W-1:0] i_entry,
    input  logic [LEN_W-1:0]  i_word_length,
    input  logic              i_case_fold,
    output t_cmp              o_cmp
);

    logic [LEN_W-1:0]     len_sat;
    logic [MAX_CHARS-1:0] stop;
    logic [MAX_CHARS-1:0] less;

    always_comb begin
        if (i_word_length == '0) begin
            len_sat = LEN_W'(1);
        end else if (i_word_length > LEN_W'(MAX_CHARS)) begin
            len_sat = LEN_W'(MAX_CHARS);
        end else begin
            len_sat = i_word_length;
        end
    end

    // per character: does the compare end here, and which way
    always_comb begin
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        for (int i = 0; i < MAX_CHARS; i++) begin
            a = fold_char(i_key[WORD_W-1-CHAR_W*i -: CHAR_W], i_case_fold);
            b = fold_char(i_entry[WORD_W-1-CHAR_W*i -: CHAR_W], i_case_fold);
            stop[i] = (LEN_W'(i) < len_sat) && ((a != b) || (a == '0));
            less[i] = a < b;
        end
    end

    // first stopping character decides; a shared zero character means equal
    always_comb begin
        o_cmp.eq = 1'b1;
        o_cmp.lt = 1'b0;
        for (int i = MAX_CHARS - 1; i >= 0; i--) begin
            if (stop[i]) begin
                o_cmp.lt = less[i];
                o_cmp.eq = 1'b0;
                if (!less[i]) begin
                    o_cmp.eq = 1'b1;
                end
            end
        end
        // a stop without a difference is the zero-character case
        o_cmp.eq = 1'b1;
        for (int i = MAX_CHARS - 1; i >= 0; i--) begin
            if (stop[i]) begin
                o_cmp.eq = 1'b0;
                if (i_key[WORD_W-1-CHAR_W*i -: CHAR_W] == i_entry[WORD_W-1-CHAR_W*i -: CHAR_W]
                    || fold_char(i_key[WORD_W-1-CHAR_W*i -: CHAR_W], i_case_fold)
                       == fold_char(i_entry[WORD_W-1-CHAR_W*i -: CHAR_W], i_case_fold)) begin
                    o_cmp.eq = 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/swts_seq.sv =====
// ----------------------------------------------------------------------------
// Bisection sequencer
// Holds the search bounds, drives the table read address and reuses the
// compare unit once per probe.
// ----------------------------------------------------------------------------
module swts_seq
    import swts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [WORD_W-1:0] i_key,
    input  t_cfg              i_cfg,
    input  logic [WORD_W-1:0] i_rdata,
    output logic [ADDR_W-1:0] o_raddr,
    output logic              o_busy,
    output logic              o_done,
    output t_result           o_res
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_lo, n_lo;
    logic [IDX_W-1:0]  r_hi, n_hi;
    logic [IDX_W-1:0]  r_mid, n_mid;
    logic [WORD_W-1:0] r_key, n_key;
    t_result           r_res, n_res;
    logic              r_done, n_done;

    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  count_sat;
    logic              open_range;
    t_cmp              cmp;

    assign mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign open_range = r_lo <= r_hi;
    assign count_sat  = (i_cfg.entry_count > IDX_W'(TABLE_DEPTH)) ?
                        IDX_W'(TABLE_DEPTH) : i_cfg.entry_count;
    assign o_raddr    = ADDR_W'(mid - IDX_W'(1));

    swts_cmp u_cmp (
        .i_key         (r_key),
        .i_entry       (i_rdata),
        .i_word_length (i_cfg.word_length),
        .i_case_fold   (i_cfg.case_fold),
        .o_cmp         (cmp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_state = open_range ? S_READ : S_IDLE;
            end
            S_READ: begin
                n_state = cmp.eq ? S_IDLE : S_PROBE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_mid  = r_mid;
        n_key  = r_key;
        n_res  = r_res;
        n_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_lo  = IDX_W'(1);
                    n_hi  = count_sat;
                    n_key = i_key;
                end
            end
            S_PROBE: begin
                if (open_range) begin
                    n_mid = mid;
                end else begin
                    n_done         = 1'b1;
                    n_res.found    = 1'b0;
                    n_res.location = '0;
                    n_res.answer   = '0;
                end
            end
            S_READ: begin
                if (cmp.eq) begin
                    n_done         = 1'b1;
                    n_res.found    = 1'b1;
                    n_res.location = r_mid;
                    unique case (i_cfg.result_mode)
                        MODE_COUNT:    n_res.answer = IDX_W'(1);
                        MODE_LOCATION: n_res.answer = r_mid;
                        default:       n_res.answer = '0;
                    endcase
                end else if (cmp.lt) begin
                    n_hi = r_mid - IDX_W'(1);
                end else begin
                    n_lo = r_mid + IDX_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lo    <= '0;
            r_hi    <= '0;
            r_mid   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_mid   <= n_mid;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/swts_chk.sv =====
// ----------------------------------------------------------------------------
// Search unit port checker
// Watches the top-level ports for sequencing and result consistency.
// ----------------------------------------------------------------------------
module swts_chk
    import swts_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             i_action,
    input logic             o_done,
    input logic             o_found,
    input logic [IDX_W-1:0] o_location,
    input logic [IDX_W-1:0] o_answer
);

    // a result comes out only once the search has released the unit
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_SEARCH) |=> busy)
        else $error("search transaction did not raise busy");

    // a load produces no result and never holds the unit
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_LOAD) |=> (!busy && !o_done))
        else $error("load transaction raised busy or a result");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_location == '0 && o_answer == '0))
        else $error("miss with nonzero location or answer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

endmodule

bind sorted_word_table_search_unit swts_chk u_swts_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_action   (i_action),
    .o_done     (o_done),
    .o_found    (o_found),
    .o_location (o_location),
    .o_answer   (o_answer)
);
